### hdl/rbp_pkg.sv
// Shared types and constants for the resource barrier planner.
// Holds state, kind and cause codes, the table entry layout and the lookup and decision structs.
// No dependencies.
package rbp_pkg;

  // Field widths, fixed by the access and transition formats.
  localparam int unsigned ResIdxW  = 6;
  localparam int unsigned PassIdxW = 8;

  // Default table depth and the number of legal pass indexes.
  localparam int unsigned ResourceSlotsDef = 64;
  localparam int unsigned PassSlots        = 256;

  typedef enum logic [1:0] {
    StUnknown   = 2'd0,
    StRead      = 2'd1,
    StWrite     = 2'd2,
    StReadWrite = 2'd3
  } res_state_e;

  localparam logic [1:0] KindGraphics = 2'd0;
  localparam logic [1:0] KindCompute  = 2'd1;
  localparam logic [1:0] KindOtherA   = 2'd2;
  localparam logic [1:0] KindOtherB   = 2'd3;

  typedef enum logic [2:0] {
    CauseRaw      = 3'd0,
    CauseWar      = 3'd1,
    CauseWaw      = 3'd2,
    CauseGfxToCmp = 3'd3,
    CauseCmpToGfx = 3'd4
  } cause_e;

  // One table entry: what the last access left behind.
  typedef struct packed {
    res_state_e            state;
    logic [PassIdxW-1:0]   pass;
    logic [1:0]            kind;
  } entry_t;

  // Table lookup for the access in the execute stage.
  typedef struct packed {
    logic   hit;
    entry_t entry;
  } lookup_t;

  // Transition decision for one access.
  typedef struct packed {
    logic                emit;
    logic [PassIdxW-1:0] before_pass;
    res_state_e          before_state;
    cause_e              cause;
  } decision_t;

endpackage

### hdl/resource_barrier_planner_top.sv
// Top level of the resource barrier planner.
// Instantiates rbp_table (state memory) and rbp_decide (transition logic).
// Depends on rbp_pkg.

// The planner takes one resource access per beat, in schedule order, and
// reports a state transition whenever a resource in a known state changes
// state, is written after a write, or moves between the graphics and
// compute queues. An access is taken at every clock edge where start_i is
// high and busy_o is low; busy_o stays low, so a new access may be offered
// in every cycle. The table is read at the edge that takes the access, the
// following cycle decides and writes back, and the result register then
// drives the transition on the result ports, marked by result_valid_o for
// exactly one cycle. The receiver cannot stall the planner and must take
// each result beat as it appears. Accesses to the same resource in
// consecutive cycles are handled by forwarding the last write-back around
// the memory. An access with new_graph_i set forgets every resource before
// it is looked up. An access whose resource or pass index is out of range
// produces no result and leaves the table untouched, although its
// new_graph_i flag still takes effect. There is no clearing pass after
// reset: valid bits are held in flip-flops and cleared at once.
module resource_barrier_planner_top #(
  parameter int unsigned RESOURCE_SLOTS = rbp_pkg::ResourceSlotsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  logic                           new_graph_i,
  input  logic [rbp_pkg::ResIdxW-1:0]    resource_index_i,
  input  logic [rbp_pkg::PassIdxW-1:0]   pass_index_i,
  input  logic [1:0]                     required_state_i,
  input  logic                           is_write_i,
  input  logic [1:0]                     pass_kind_i,
  output logic                           result_valid_o,
  output logic [rbp_pkg::ResIdxW-1:0]    resource_out_o,
  output logic [rbp_pkg::PassIdxW-1:0]   before_pass_o,
  output logic [1:0]                     before_state_o,
  output logic [rbp_pkg::PassIdxW-1:0]   after_pass_o,
  output logic [1:0]                     after_state_o,
  output logic [2:0]                     cause_o
);
  import rbp_pkg::*;

  // Only as many entries as the resource index can address are ever used.
  localparam int unsigned IdxSpan = 2 ** ResIdxW;
  localparam int unsigned Depth   = (RESOURCE_SLOTS < IdxSpan) ? RESOURCE_SLOTS : IdxSpan;
  localparam int unsigned AddrW   = $clog2(Depth);

  typedef struct packed {
    logic                new_graph;
    logic                in_range;
    logic [ResIdxW-1:0]  res;
    logic [PassIdxW-1:0] pass;
    res_state_e          req;
    logic                wr;
    logic [1:0]          kind;
  } exe_t;

  logic      accept;
  logic      in_range;
  logic      exe_valid_q;
  exe_t      exe_q;
  logic      wr_en;
  logic      clr_all;
  entry_t    wr_data;
  lookup_t   lookup;
  decision_t decision;
  logic      out_valid_q;

  // The pipeline never needs to hold an access back.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  assign in_range = (32'(resource_index_i) < RESOURCE_SLOTS)
                 && (32'(pass_index_i) < PassSlots);

  // Read stage: the memory read is issued while the access is registered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exe_valid_q <= 1'b0;
    end else begin
      exe_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      exe_q.new_graph <= new_graph_i;
      exe_q.in_range  <= in_range;
      exe_q.res       <= resource_index_i;
      exe_q.pass      <= pass_index_i;
      exe_q.req       <= res_state_e'(required_state_i);
      exe_q.wr        <= is_write_i;
      exe_q.kind      <= pass_kind_i;
    end
  end

  // Execute stage: decide on the transition and write the access back.
  assign clr_all = exe_valid_q && exe_q.new_graph;
  assign wr_en   = exe_valid_q && exe_q.in_range;

  always_comb begin
    wr_data.state = exe_q.req;
    wr_data.pass  = exe_q.pass;
    wr_data.kind  = exe_q.kind;
  end

  rbp_table #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr_i  (resource_index_i[AddrW-1:0]),
    .lkp_addr_i (exe_q.res[AddrW-1:0]),
    .clr_all_i  (clr_all),
    .wr_en_i    (wr_en),
    .wr_addr_i  (exe_q.res[AddrW-1:0]),
    .wr_data_i  (wr_data),
    .lookup_o   (lookup)
  );

  rbp_decide u_decide (
    .lookup_i    (lookup),
    .in_range_i  (exe_q.in_range),
    .req_state_i (exe_q.req),
    .is_write_i  (exe_q.wr),
    .pass_kind_i (exe_q.kind),
    .decision_o  (decision)
  );

  // Result register: one beat per emitted transition.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= exe_valid_q && decision.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exe_valid_q && decision.emit) begin
      resource_out_o <= exe_q.res;
      before_pass_o  <= decision.before_pass;
      before_state_o <= decision.before_state;
      after_pass_o   <= exe_q.pass;
      after_state_o  <= exe_q.req;
      cause_o        <= decision.cause;
    end
  end

  assign result_valid_o = out_valid_q;

endmodule

### hdl/rbp_table.sv
// Per-resource state table of the resource barrier planner.
// One synchronous memory with forwarding, plus valid bits in flip-flops.
// Depends on rbp_pkg.
module rbp_table #(
  parameter int unsigned Depth = rbp_pkg::ResourceSlotsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  input  logic [AddrW-1:0] lkp_addr_i,
  input  logic             clr_all_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  rbp_pkg::entry_t  wr_data_i,
  output rbp_pkg::lookup_t lookup_o
);
  import rbp_pkg::*;

  entry_t             mem_q [Depth];
  entry_t             rd_data_q;
  logic [Depth-1:0]   valid_q;
  logic [Depth-1:0]   valid_d;
  logic               fwd_valid_q;
  logic [AddrW-1:0]   fwd_addr_q;
  entry_t             fwd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // The read issued at the same edge as a write returns the old data, so the
  // last write is kept in a forwarding register and forwarded on an address match.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= wr_en_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      fwd_addr_q <= wr_addr_i;
      fwd_data_q <= wr_data_i;
    end
  end

  // A clear and a write at the same edge leave only the written entry valid.
  always_comb begin
    valid_d = clr_all_i ? '0 : valid_q;
    if (wr_en_i) begin
      valid_d[wr_addr_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_comb begin
    lookup_o.hit   = !clr_all_i && valid_q[lkp_addr_i];
    lookup_o.entry = (fwd_valid_q && (fwd_addr_q == lkp_addr_i)) ? fwd_data_q : rd_data_q;
  end

endmodule

### hdl/rbp_decide.sv
// Transition decision of the resource barrier planner.
// Compares the table lookup with the current access and picks the cause.
// Depends on rbp_pkg.
module rbp_decide (
  input  rbp_pkg::lookup_t   lookup_i,
  input  logic               in_range_i,
  input  rbp_pkg::res_state_e req_state_i,
  input  logic               is_write_i,
  input  logic [1:0]         pass_kind_i,
  output rbp_pkg::decision_t decision_o
);
  import rbp_pkg::*;

  res_state_e cur;
  logic [1:0] last_kind;
  logic       waw;
  logic       state_emit;
  logic       queue_emit;

  always_comb begin
    cur       = lookup_i.hit ? lookup_i.entry.state : StUnknown;
    last_kind = lookup_i.hit ? lookup_i.entry.kind : KindGraphics;
    waw       = lookup_i.hit && is_write_i && (cur == StWrite || cur == StReadWrite);
    state_emit = (cur != StUnknown) && ((cur != req_state_i) || waw);
    queue_emit = lookup_i.hit && (last_kind != pass_kind_i)
               && !last_kind[1] && !pass_kind_i[1];

    decision_o.emit         = in_range_i && (state_emit || queue_emit);
    decision_o.before_pass  = lookup_i.entry.pass;
    decision_o.before_state = cur;

    // Queue switches take priority over hazards.
    if (last_kind == KindGraphics && pass_kind_i == KindCompute) begin
      decision_o.cause = CauseGfxToCmp;
    end else if (last_kind == KindCompute && pass_kind_i == KindGraphics) begin
      decision_o.cause = CauseCmpToGfx;
    end else if (cur == StWrite && req_state_i == StRead) begin
      decision_o.cause = CauseRaw;
    end else if (cur == StRead && req_state_i == StWrite) begin
      decision_o.cause = CauseWar;
    end else begin
      decision_o.cause = CauseWaw;
    end
  end

endmodule
